// ===== hw/rtl/rth_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
package rth_pkg;

  localparam int unsigned ChanW   = 8;   // width of one color channel
  localparam int unsigned QuoBits = 8;   // quotient bits, one cell per bit
  localparam int unsigned NumCells = QuoBits;
  localparam int unsigned HueRemW = 11;  // holds 6*d up to 1530
  localparam int unsigned SatRemW = ChanW;

  // Payload handed from cell to cell along the divider chain.
  typedef struct packed {
    logic [HueRemW-1:0] h_rem;
    logic [HueRemW-1:0] h_den;
    logic [QuoBits-1:0] h_quo;
    logic [SatRemW-1:0] s_rem;
    logic [SatRemW-1:0] s_den;
    logic [QuoBits-1:0] s_quo;
    logic               s_full;
    logic [ChanW-1:0]   value;
  } rth_cell_t;

endpackage

// ===== hw/rtl/rth_if.sv =====
// Pixel input and HSV output channel interfaces.
interface rth_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rth_pkg::ChanW-1:0]   red;
  logic [rth_pkg::ChanW-1:0]   green;
  logic [rth_pkg::ChanW-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if;
  logic                        valid;
  logic                        ready;
  logic [rth_pkg::ChanW-1:0]   hue;
  logic [rth_pkg::ChanW-1:0]   saturation;
  logic [rth_pkg::ChanW-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== hw/rtl/rth_front.sv =====
// Front stage: channel ordering, value, and hue/saturation division operands.
module rth_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [rth_pkg::ChanW-1:0] red_i,
  input  logic [rth_pkg::ChanW-1:0] green_i,
  input  logic [rth_pkg::ChanW-1:0] blue_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output rth_pkg::rth_cell_t        data_o
);

  logic                      g_ge_b, r_top;
  logic [rth_pkg::ChanW-1:0] hi1, lo1, mx, other, mn, dlt;
  logic [rth_pkg::HueRemW-1:0] six_d;
  logic signed [8:0]         diff_s;
  logic signed [12:0]        term_s, num_s;
  logic [12:0]               num_abs;
  rth_pkg::rth_cell_t        data_d, data_q;
  logic                      valid_q;

  always_comb begin
    g_ge_b = green_i >= blue_i;
    hi1    = g_ge_b ? green_i : blue_i;
    lo1    = g_ge_b ? blue_i : green_i;
    r_top  = red_i >= hi1;
    mx     = r_top ? red_i : hi1;
    other  = r_top ? hi1 : red_i;
    mn     = (other < lo1) ? other : lo1;
    dlt    = mx - mn;
    six_d  = {1'b0, dlt, 2'b00} + {2'b00, dlt, 1'b0};
    diff_s = $signed({1'b0, other}) - $signed({1'b0, lo1});

    // hue offset in thirds of a turn, scaled by 2*d
    unique case ({r_top, g_ge_b})
      2'b11: term_s = '0;
      2'b10: term_s = -$signed({2'b00, six_d});
      2'b01: term_s = -$signed({4'b0000, dlt, 1'b0});
      2'b00: term_s = $signed({3'b000, dlt, 2'b00});
      default: term_s = '0;
    endcase
    num_s   = term_s + 13'(diff_s);
    num_abs = num_s[12] ? -num_s : num_s;

    // |num| < 6*d whenever d is nonzero, so it fits the hue remainder
    data_d.h_rem  = num_abs[rth_pkg::HueRemW-1:0];
    data_d.h_den  = (dlt == '0) ? rth_pkg::HueRemW'(1) : six_d;
    data_d.h_quo  = '0;
    data_d.s_full = (mn == '0) && (mx != '0);
    data_d.s_rem  = data_d.s_full ? '0 : dlt;
    data_d.s_den  = (mx == '0) ? rth_pkg::SatRemW'(1) : mx;
    data_d.s_quo  = '0;
    data_d.value  = mx;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/rth_cell.sv =====
// One divider cell: produces one hue and one saturation quotient bit.
module rth_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rth_pkg::rth_cell_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rth_pkg::rth_cell_t data_o
);

  logic [rth_pkg::HueRemW:0] h_sh, h_sub;
  logic [rth_pkg::SatRemW:0] s_sh, s_sub;
  logic                      h_ge, s_ge;
  rth_pkg::rth_cell_t        data_d, data_q;
  logic                      valid_q;

  always_comb begin
    h_sh  = {data_i.h_rem, 1'b0};
    h_sub = h_sh - {1'b0, data_i.h_den};
    h_ge  = h_sh >= {1'b0, data_i.h_den};
    s_sh  = {data_i.s_rem, 1'b0};
    s_sub = s_sh - {1'b0, data_i.s_den};
    s_ge  = s_sh >= {1'b0, data_i.s_den};

    data_d       = data_i;
    // remainder stays below the divisor, so the top bit drops
    data_d.h_rem = h_ge ? h_sub[rth_pkg::HueRemW-1:0] : h_sh[rth_pkg::HueRemW-1:0];
    data_d.h_quo = {data_i.h_quo[rth_pkg::QuoBits-2:0], h_ge};
    data_d.s_rem = s_ge ? s_sub[rth_pkg::SatRemW-1:0] : s_sh[rth_pkg::SatRemW-1:0];
    data_d.s_quo = {data_i.s_quo[rth_pkg::QuoBits-2:0], s_ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/rgb_to_hsv_8bit.sv =====
// Pipeline: 1 front stage + 8 divider cells, each a registered stage.
// Throughput: one pixel per cycle unless hsv_o stalls; each cell resolves one
// quotient bit of hue and saturation; empty cells keep taking requests in a stall.
// Reset: asynchronous active-low rst_ni clears all stage valid flags; payload
// registers are not reset. No state carries between pixels.
module rgb_to_hsv_8bit (
  input  logic          clk_i,
  input  logic          rst_ni,
  rth_pix_if.sink       pix_i,
  rth_hsv_if.source     hsv_o
);

  rth_pkg::rth_cell_t                   cdata [rth_pkg::NumCells+1];
  logic [rth_pkg::NumCells:0]           cvalid;
  logic [rth_pkg::NumCells:0]           cready;
  rth_pkg::rth_cell_t                   last;

  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (cvalid[0]),
    .ready_i (cready[0]),
    .data_o  (cdata[0])
  );

  for (genvar i = 0; i < rth_pkg::NumCells; i++) begin : g_cell
    rth_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cvalid[i]),
      .ready_o (cready[i]),
      .data_i  (cdata[i]),
      .valid_o (cvalid[i+1]),
      .ready_i (cready[i+1]),
      .data_o  (cdata[i+1])
    );
  end

  assign cready[rth_pkg::NumCells] = hsv_o.ready;
  assign last             = cdata[rth_pkg::NumCells];
  assign hsv_o.valid      = cvalid[rth_pkg::NumCells];
  assign hsv_o.hue        = last.h_quo;
  // min of zero gives a ratio of exactly one, shown as full scale
  assign hsv_o.saturation = last.s_full ? '1 : last.s_quo;
  assign hsv_o.brightness = last.value;

  a_front_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> cvalid[0])
    else $error("accepted request did not reach the front stage");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_o.valid |-> pix_i.ready)
    else $error("input stalled with an empty output stage");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.brightness == '0 |-> hsv_o.saturation == '0 && hsv_o.hue == '0)
    else $error("black pixel with nonzero hue or saturation");

endmodule
